// ----- rtl/core/micro_branch_target_buffer_unit_macros.svh -----
// Assertion macros shared by the micro branch target buffer RTL
`ifndef MICRO_BRANCH_TARGET_BUFFER_UNIT_MACROS_SVH
`define MICRO_BRANCH_TARGET_BUFFER_UNIT_MACROS_SVH
// implication checked every cycle outside reset
`define MBTB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define MBTB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- rtl/core/mbtb_pkg.sv -----
// Package: types, constants and helpers for the micro branch target buffer
`default_nettype none
package mbtb_pkg;
  localparam int unsigned WAYS_DEF = 16;

  localparam logic [1:0] FUNC_PREDICT = 2'd0;
  localparam logic [1:0] FUNC_INSERT  = 2'd1;
  localparam logic [1:0] FUNC_INVAL   = 2'd2;

  localparam logic CFG_TAG_SHIFT = 1'b0;
  localparam logic CFG_TAG_BITS  = 1'b1;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] pc;
    logic [63:0] new_target;
    logic [1:0]  new_span;
    logic        new_sign;
  } in_word_t;

  typedef struct packed {
    logic        hit;
    logic [63:0] target;
    logic [1:0]  span;
    logic        sign;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture input word and form tag
    logic lookup;  // register hit flag, hit way and victim
    logic commit;  // update table, build result
  } mbtb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic busy;
  } mbtb_sts_t;
endpackage
`default_nettype wire

// ----- rtl/core/mbtb_ctrl.sv -----
// Controller: sequences load, lookup, commit and result handoff
`default_nettype none
module mbtb_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output mbtb_pkg::mbtb_cmd_t    cmd,
  input  wire mbtb_pkg::mbtb_sts_t sts
);
  import mbtb_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOOKUP = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;
  localparam logic [1:0] ST_OUT    = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       acc;

  assign in_stall  = (state_r != ST_IDLE);
  assign acc       = in_valid && !in_stall;
  assign out_valid = (state_r == ST_OUT);

  always_comb begin
    cmd        = '0;
    cmd.load   = acc;
    cmd.lookup = (state_r == ST_LOOKUP);
    cmd.commit = (state_r == ST_COMMIT);
    state_nxt  = state_r;
    unique case (state_r)
      ST_IDLE:   if (acc) state_nxt = ST_LOOKUP;
      ST_LOOKUP: state_nxt = ST_COMMIT;
      ST_COMMIT: state_nxt = ST_OUT;
      ST_OUT:    if (!out_stall) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

`include "micro_branch_target_buffer_unit_macros.svh"
  `MBTB_ASSERT_NXT(a_load_to_lookup, clk, rst_n, cmd.load, cmd.lookup, "load not followed by lookup")
  `MBTB_ASSERT_NXT(a_commit_to_out, clk, rst_n, cmd.commit, out_valid, "commit without result")
  `MBTB_ASSERT_IMP(a_busy_stall, clk, rst_n, sts.busy, in_stall, "accepting while busy")
endmodule
`default_nettype wire

// ----- rtl/core/mbtb_dpath.sv -----
// Datapath: way table, tag compare, LRU ranks and result register
`default_nettype none
module mbtb_dpath #(
  parameter int unsigned WAYS = mbtb_pkg::WAYS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire mbtb_pkg::mbtb_cmd_t  cmd,
  output mbtb_pkg::mbtb_sts_t       sts,
  input  wire mbtb_pkg::in_word_t   in_word,
  input  wire logic [5:0]           tag_shift,
  input  wire logic [6:0]           tag_bits,
  output mbtb_pkg::out_word_t       out_word
);
  import mbtb_pkg::*;

  localparam int unsigned WW = (WAYS > 1) ? $clog2(WAYS) : 1;

  logic [WAYS-1:0]  valid_r;
  logic [63:0]      tag_r    [WAYS];
  logic [63:0]      tgt_r    [WAYS];
  logic [1:0]       span_r   [WAYS];
  logic             sign_r   [WAYS];
  logic [WW-1:0]    age_r    [WAYS];

  in_word_t         req_r;
  logic [63:0]      key_r;
  logic             hit_r;
  logic [WW-1:0]    hway_r;
  logic [WW-1:0]    vway_r;
  out_word_t        res_r;

  // tag formation
  logic [63:0] shifted, mask, key_nxt;
  always_comb begin
    shifted = in_word.pc >> tag_shift;
    if (tag_bits[6]) mask = '1;
    else mask = ~(64'hFFFF_FFFF_FFFF_FFFF << tag_bits[5:0]);
    key_nxt = shifted & mask;
  end

  // match search and victim choice
  logic              hit_nxt, inv_any;
  logic [WW-1:0]     hway_nxt, inv_way, lru_way, vway_nxt;
  always_comb begin
    hit_nxt  = 1'b0;
    hway_nxt = '0;
    inv_any  = 1'b0;
    inv_way  = '0;
    lru_way  = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (valid_r[i] && tag_r[i] == key_r) begin
        hit_nxt  = 1'b1;
        hway_nxt = WW'(i);
      end
      if (!valid_r[i]) begin
        inv_any = 1'b1;
        inv_way = WW'(i);
      end
      if (age_r[i] == '0) lru_way = WW'(i);
    end
    vway_nxt = hit_nxt ? hway_nxt : (inv_any ? inv_way : lru_way);
  end

  // which way gets touched at commit
  logic          touch;
  logic [WW-1:0] tway;
  always_comb begin
    touch = 1'b0;
    tway  = hway_r;
    unique case (req_r.func)
      FUNC_PREDICT: touch = hit_r;
      FUNC_INSERT: begin
        touch = 1'b1;
        tway  = vway_r;
      end
      FUNC_INVAL: touch = hit_r;
      default: touch = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_word;
      key_r <= key_nxt;
    end
    if (cmd.lookup) begin
      hit_r  <= hit_nxt;
      hway_r <= hway_nxt;
      vway_r <= vway_nxt;
    end
    if (cmd.commit) begin
      if (req_r.func == FUNC_PREDICT && hit_r) begin
        res_r <= '{hit: 1'b1, target: tgt_r[hway_r], span: span_r[hway_r],
                   sign: sign_r[hway_r]};
      end else begin
        res_r <= '0;
      end
      if (req_r.func == FUNC_INSERT) begin
        tag_r[vway_r]  <= key_r;
        tgt_r[vway_r]  <= req_r.new_target;
        span_r[vway_r] <= req_r.new_span;
        sign_r[vway_r] <= req_r.new_sign;
      end
    end
  end

  // valid bits and recency ranks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      for (int i = 0; i < WAYS; i++) age_r[i] <= WW'(i);
    end else if (cmd.commit) begin
      if (req_r.func == FUNC_INSERT) valid_r[vway_r] <= 1'b1;
      if (req_r.func == FUNC_INVAL && hit_r) valid_r[hway_r] <= 1'b0;
      if (touch) begin
        for (int i = 0; i < WAYS; i++) begin
          if (WW'(i) == tway) age_r[i] <= WW'(WAYS - 1);
          else if (age_r[i] > age_r[tway]) age_r[i] <= age_r[i] - 1'b1;
        end
      end
    end
  end

  assign sts.busy = cmd.lookup | cmd.commit;
  assign out_word = res_r;

`include "micro_branch_target_buffer_unit_macros.svh"
  `MBTB_ASSERT_NXT(a_ins_valid, clk, rst_n, cmd.commit && req_r.func == FUNC_INSERT, valid_r[$past(vway_r)], "insert left way invalid")
  `MBTB_ASSERT_NXT(a_miss_zero, clk, rst_n, cmd.commit && !hit_r, !res_r.hit, "hit flag on miss")
  `MBTB_ASSERT_IMP(a_one_cmd, clk, rst_n, 1'b1, $onehot0(cmd), "overlapping commands")
endmodule
`default_nettype wire

// ----- rtl/core/micro_branch_target_buffer_unit.sv -----
// Top level: micro branch target buffer, controller plus datapath
//   channel | direction | handshake         | word
//   in_     | in        | in_valid/in_stall  | func, pc, new_target, new_span, new_sign
//   out_    | out       | out_valid/out_stall| hit, target, span, sign
//   cfg_    | in        | cfg_valid/cfg_ready| index 0 tag_shift, 1 tag_bits
// One word at a time: accept and tag form, compare, commit, hand off.
// The result becomes valid after the LOOKUP and COMMIT states that follow acceptance; input reopens once it is taken.
// Synchronous reset clears valid bits, ranks to way order, tag_shift 0, tag_bits 32.
// A stalled result holds; input stays stalled until the result is taken.
`default_nettype none
module micro_branch_target_buffer_unit #(
  parameter int unsigned WAYS = mbtb_pkg::WAYS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire mbtb_pkg::in_word_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output mbtb_pkg::out_word_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic                cfg_index,
  input  wire logic [6:0]          cfg_data
);
  import mbtb_pkg::*;

  mbtb_cmd_t  cmd;
  mbtb_sts_t  sts;
  logic [5:0] tag_shift_r;
  logic [6:0] tag_bits_r;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_shift_r <= '0;
      tag_bits_r  <= 7'd32;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TAG_SHIFT: tag_shift_r <= cfg_data[5:0];
        CFG_TAG_BITS:  tag_bits_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  mbtb_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts)
  );

  mbtb_dpath #(.WAYS(WAYS)) u_dpath (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_word(in_data),
    .tag_shift(tag_shift_r), .tag_bits(tag_bits_r), .out_word(out_data)
  );
endmodule
`default_nettype wire
